// ----- hw/rtl/bls_pkg.sv -----
// Package with the opcodes and the fixed color width of the Bresenham line stepper.
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

    localparam int COLOR_BITS = 8;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bresenham_line_stepper_top.sv -----
// Top level of the Bresenham line stepper: line set-up, pixel stepping and result register.
`timescale 1ns / 1ps
`default_nettype none

// Each input word yields exactly one result word, which the result register takes when the
// word is accepted. A start word sets up a line in any octant and returns its first pixel;
// each advance word returns the next pixel and flags the last one. An advance word with no
// line in progress returns a word with pixel_valid low and all other fields zero. The block
// takes one word per cycle: the set-up and the step are combinational logic ahead of the
// result register, and s_ready stays high whenever the result register is empty or being read.
module bresenham_line_stepper_top #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_opcode,
    input  wire logic [COORD_BITS-1:0]           s_start_x,
    input  wire logic [COORD_BITS-1:0]           s_start_y,
    input  wire logic [COORD_BITS-1:0]           s_end_x,
    input  wire logic [COORD_BITS-1:0]           s_end_y,
    input  wire logic [bls_pkg::COLOR_BITS-1:0]  s_color,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [COORD_BITS-1:0]                m_pixel_x,
    output logic [COORD_BITS-1:0]                m_pixel_y,
    output logic [bls_pkg::COLOR_BITS-1:0]       m_pixel_color,
    output logic                                 m_pixel_valid,
    output logic                                 m_last_pixel
);

    localparam int EW = COORD_BITS + 3;
    localparam int BW = COORD_BITS + 2;

    // Line state
    logic [COORD_BITS-1:0]          cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]          cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]          major_end_reg, major_end_next;
    logic signed [EW-1:0]           error_term_reg, error_term_next;
    logic signed [EW-1:0]           step_incr_a_reg, step_incr_a_next;
    logic [BW-1:0]                  step_incr_b_reg, step_incr_b_next;
    logic                           minor_down_reg, minor_down_next;
    logic                           y_is_major_reg, y_is_major_next;
    logic [bls_pkg::COLOR_BITS-1:0] line_color_reg, line_color_next;
    logic                           active_reg, active_next;

    // Result register
    logic                           m_valid_reg;
    logic [COORD_BITS-1:0]          m_pixel_x_reg, m_pixel_x_next;
    logic [COORD_BITS-1:0]          m_pixel_y_reg, m_pixel_y_next;
    logic [bls_pkg::COLOR_BITS-1:0] m_pixel_color_reg, m_pixel_color_next;
    logic                           m_pixel_valid_reg, m_pixel_valid_next;
    logic                           m_last_pixel_reg, m_last_pixel_next;

    logic                           in_fire;
    logic                           is_start;

    // Set-up signals
    logic [COORD_BITS-1:0]          abs_dx, abs_dy, dmaj, dmin;
    logic                           su_y_major, su_swap, su_minor_down;

    // Step signals
    logic [COORD_BITS-1:0]          maj_cur, mnr_cur, maj_new, mnr_new;
    logic                           err_nonneg, step_last;

    assign s_ready  = !m_valid_reg || m_ready;
    assign in_fire  = s_valid && s_ready;
    assign is_start = (s_opcode == bls_pkg::OP_START);

    always_comb begin
        abs_dx     = (s_start_x > s_end_x) ? (s_start_x - s_end_x) : (s_end_x - s_start_x);
        abs_dy     = (s_start_y > s_end_y) ? (s_start_y - s_end_y) : (s_end_y - s_start_y);
        su_y_major = (abs_dx < abs_dy);
        dmaj       = su_y_major ? abs_dy : abs_dx;
        dmin       = su_y_major ? abs_dx : abs_dy;
        if (su_y_major) begin
            su_swap       = (s_start_y > s_end_y);
            su_minor_down = su_swap ? !(s_start_x > s_end_x) : !(s_end_x > s_start_x);
        end else begin
            su_swap       = (s_start_x > s_end_x);
            su_minor_down = su_swap ? !(s_start_y > s_end_y) : !(s_end_y > s_start_y);
        end
    end

    always_comb begin
        maj_cur    = y_is_major_reg ? cur_y_reg : cur_x_reg;
        mnr_cur    = y_is_major_reg ? cur_x_reg : cur_y_reg;
        err_nonneg = !error_term_reg[EW-1];
        maj_new    = maj_cur + {{(COORD_BITS-1){1'b0}}, 1'b1};
        if (!err_nonneg) begin
            mnr_new = mnr_cur;
        end else if (minor_down_reg) begin
            mnr_new = mnr_cur - {{(COORD_BITS-1){1'b0}}, 1'b1};
        end else begin
            mnr_new = mnr_cur + {{(COORD_BITS-1){1'b0}}, 1'b1};
        end
        step_last = (maj_new == major_end_reg);
    end

    always_comb begin
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        major_end_next     = major_end_reg;
        error_term_next    = error_term_reg;
        step_incr_a_next   = step_incr_a_reg;
        step_incr_b_next   = step_incr_b_reg;
        minor_down_next    = minor_down_reg;
        y_is_major_next    = y_is_major_reg;
        line_color_next    = line_color_reg;
        active_next        = active_reg;
        m_pixel_x_next     = m_pixel_x_reg;
        m_pixel_y_next     = m_pixel_y_reg;
        m_pixel_color_next = m_pixel_color_reg;
        m_pixel_valid_next = m_pixel_valid_reg;
        m_last_pixel_next  = m_last_pixel_reg;
        if (in_fire) begin
            if (is_start) begin
                cur_x_next       = su_swap ? s_end_x : s_start_x;
                cur_y_next       = su_swap ? s_end_y : s_start_y;
                if (su_y_major) begin
                    major_end_next = su_swap ? s_start_y : s_end_y;
                end else begin
                    major_end_next = su_swap ? s_start_x : s_end_x;
                end
                error_term_next  = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
                step_incr_a_next = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
                step_incr_b_next = {1'b0, dmin, 1'b0};
                minor_down_next  = su_minor_down;
                y_is_major_next  = su_y_major;
                line_color_next  = s_color;
                active_next      = (dmaj != '0);
                m_pixel_x_next     = su_swap ? s_end_x : s_start_x;
                m_pixel_y_next     = su_swap ? s_end_y : s_start_y;
                m_pixel_color_next = s_color;
                m_pixel_valid_next = 1'b1;
                m_last_pixel_next  = (dmaj == '0);
            end else if (active_reg) begin
                cur_x_next      = y_is_major_reg ? mnr_new : maj_new;
                cur_y_next      = y_is_major_reg ? maj_new : mnr_new;
                if (err_nonneg) begin
                    error_term_next = error_term_reg + step_incr_a_reg;
                end else begin
                    error_term_next = error_term_reg + $signed({1'b0, step_incr_b_reg});
                end
                active_next        = !step_last;
                m_pixel_x_next     = y_is_major_reg ? mnr_new : maj_new;
                m_pixel_y_next     = y_is_major_reg ? maj_new : mnr_new;
                m_pixel_color_next = line_color_reg;
                m_pixel_valid_next = 1'b1;
                m_last_pixel_next  = step_last;
            end else begin
                m_pixel_x_next     = '0;
                m_pixel_y_next     = '0;
                m_pixel_color_next = '0;
                m_pixel_valid_next = 1'b0;
                m_last_pixel_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg         <= cur_x_next;
        cur_y_reg         <= cur_y_next;
        major_end_reg     <= major_end_next;
        error_term_reg    <= error_term_next;
        step_incr_a_reg   <= step_incr_a_next;
        step_incr_b_reg   <= step_incr_b_next;
        minor_down_reg    <= minor_down_next;
        y_is_major_reg    <= y_is_major_next;
        line_color_reg    <= line_color_next;
        m_pixel_x_reg     <= m_pixel_x_next;
        m_pixel_y_reg     <= m_pixel_y_next;
        m_pixel_color_reg <= m_pixel_color_next;
        m_pixel_valid_reg <= m_pixel_valid_next;
        m_last_pixel_reg  <= m_last_pixel_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_pixel_x_reg;
    assign m_pixel_y     = m_pixel_y_reg;
    assign m_pixel_color = m_pixel_color_reg;
    assign m_pixel_valid = m_pixel_valid_reg;
    assign m_last_pixel  = m_last_pixel_reg;

`ifndef SYNTHESIS
    // A word for an advance with no line in progress carries nothing but zeros.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_pixel_valid_reg) |->
            (m_pixel_x_reg == '0 && m_pixel_y_reg == '0 &&
             m_pixel_color_reg == '0 && !m_last_pixel_reg))
        else $error("idle result word has non-zero fields");

    // The line ends together with the word that carries its last pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(in_fire) && m_valid_reg && m_last_pixel_reg) |-> !active_reg)
        else $error("line still active after its last pixel");

    // A start word always produces a real pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_start) |=> (m_valid_reg && m_pixel_valid_reg))
        else $error("start word did not produce a pixel");

    // An active line has produced a pixel that was not the last one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(in_fire) && active_reg) |-> (m_pixel_valid_reg && !m_last_pixel_reg))
        else $error("line active after a word that was not a pixel");

    // Input is held off only while a result word waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire
